### design/sagd_pkg.sv
// ============================================================================
// Sensor activity gesture detector package
// Shared constants, register codes and types of the detector.
// ============================================================================
`default_nettype none

package sagd_pkg;

   // Depth of the sample window, one chain cell per entry.
   localparam int WINDOW_DEPTH = 16;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH);
   localparam int SUM_W        = 16 + CNT_W;
   localparam int SQSUM_W      = 32 + CNT_W;

   localparam logic [15:0] MID_VALUE   = 16'h7FFF;
   localparam logic [15:0] FULL_VALUE  = 16'hFFFF;
   localparam logic [15:0] EDGE_MARGIN = 16'd10;

   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_UP   = 2'd1;
   localparam logic [1:0] CODE_DOWN = 2'd2;

   // Register map, one 64-bit slot per register.
   localparam int ADDR_W = 6;
   localparam logic [2:0] REG_RAW_LOW   = 3'd0;
   localparam logic [2:0] REG_RAW_HIGH  = 3'd1;
   localparam logic [2:0] REG_SCALE     = 3'd2;
   localparam logic [2:0] REG_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_HOLD_MS   = 3'd4;

   localparam logic [15:0] RST_RAW_LOW   = 16'hFFFF;
   localparam logic [15:0] RST_RAW_HIGH  = 16'h0001;
   localparam logic [32:0] RST_SCALE     = 33'd65536;
   localparam logic [31:0] RST_THRESHOLD = 32'd0;
   localparam logic [15:0] RST_HOLD_MS   = 16'd500;

   typedef struct packed {
      logic [15:0] level;
      logic        active;
      logic [1:0]  gesture_code;
      logic [15:0] window_min;
      logic [15:0] window_max;
   } sagd_result_type;

   typedef struct packed {
      logic        commit;
      logic        active;
      logic [15:0] cur;
      logic [31:0] now;
   } sagd_decide_type;

endpackage

`default_nettype wire

### design/sagd_if.sv
// ============================================================================
// Sensor activity gesture detector channels
// Valid/ready channels for the sample input and the result output.
// ============================================================================
`default_nettype none

interface sagd_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        sample_time;
   logic signed [15:0] raw_sample;

   modport source (output valid, output sample_time, output raw_sample, input ready);
   modport sink   (input valid, input sample_time, input raw_sample, output ready);
endinterface

interface sagd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] level;
   logic        active;
   logic [1:0]  gesture_code;
   logic [15:0] window_min;
   logic [15:0] window_max;

   modport source (output valid, output level, output active, output gesture_code,
                   output window_min, output window_max, input ready);
   modport sink   (input valid, input level, input active, input gesture_code,
                   input window_min, input window_max, output ready);
endinterface

`default_nettype wire

### design/sensor_activity_gesture_detector.sv
// ============================================================================
// Sensor activity gesture detector
// Window variance activity flag with min/max up/down gesture detection.
// ============================================================================
// One sample is taken at a time and gives exactly one result. A sample passes
// the scaler's difference and product registers, and its S_SCALE state ends
// by shifting the sample into the chain of window cells. The S_SUM state then
// rotates the chain once past the single squarer and accumulators. The FLUSH,
// MEAN, VAR, CMP and DECIDE states drain the last square into the accumulators
// and form the mean, the mean square, the variance compare and the gesture
// decision. The next sample is taken in the cycle after the result enters the
// output register, so no new sample is taken while one is still in process. A
// stalled result holds the next sample in its decision step. All window cells
// reset to 0x7FFF. Registers sit at byte address 8*index, with 64-bit data.
`default_nettype none

module sensor_activity_gesture_detector import sagd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   sagd_req_if.sink               req_chan,
   sagd_rsp_if.source             rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCALE  = 3'd1;
   localparam logic [2:0] S_SUM    = 3'd2;
   localparam logic [2:0] S_FLUSH  = 3'd3;
   localparam logic [2:0] S_MEAN   = 3'd4;
   localparam logic [2:0] S_VAR    = 3'd5;
   localparam logic [2:0] S_CMP    = 3'd6;
   localparam logic [2:0] S_DECIDE = 3'd7;

   // Configuration registers.
   logic signed [15:0] raw_low_ff;
   logic signed [15:0] raw_high_ff;
   logic signed [32:0] scale_ff;
   logic [31:0]        thresh_ff;
   logic [15:0]        hold_ff;
   logic               csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_low_ff  <= RST_RAW_LOW;
         raw_high_ff <= RST_RAW_HIGH;
         scale_ff    <= RST_SCALE;
         thresh_ff   <= RST_THRESHOLD;
         hold_ff     <= RST_HOLD_MS;
      end else if (csr_write) begin
         unique case (csr_paddr[5:3])
            REG_RAW_LOW:   raw_low_ff  <= csr_pwdata[15:0];
            REG_RAW_HIGH:  raw_high_ff <= csr_pwdata[15:0];
            REG_SCALE:     scale_ff    <= csr_pwdata[32:0];
            REG_THRESHOLD: thresh_ff   <= csr_pwdata[31:0];
            REG_HOLD_MS:   hold_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_RAW_LOW:   csr_prdata = {48'd0, raw_low_ff};
         REG_RAW_HIGH:  csr_prdata = {48'd0, raw_high_ff};
         REG_SCALE:     csr_prdata = {31'd0, scale_ff};
         REG_THRESHOLD: csr_prdata = {32'd0, thresh_ff};
         REG_HOLD_MS:   csr_prdata = {48'd0, hold_ff};
         default:       csr_prdata = 64'd0;
      endcase
   end

   // Control and datapath registers.
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [31:0]        now_ff;
   logic [15:0]        cur_ff;
   logic [15:0]        val_ff;
   logic [31:0]        sq_ff;
   logic               pipe_vld_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQSUM_W-1:0] sqsum_ff;
   logic [15:0]        mean_ff;
   logic [31:0]        avg_sq_ff;
   logic [31:0]        msq_ff;
   logic               act_ff;
   logic               rsp_valid_ff;
   sagd_result_type    rsp_ff;

   logic               accept;
   logic               scale_done;
   logic [15:0]        scaled;
   logic               shift;
   logic [15:0]        head;
   logic [15:0]        chain_in;
   logic               commit;
   sagd_decide_type    decide;
   sagd_result_type    next_result;
   logic [15:0]        cell_out [WINDOW_DEPTH];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);

   sagd_scaler u_scaler (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .raw_sample   (req_chan.raw_sample),
      .raw_low      (raw_low_ff),
      .raw_high     (raw_high_ff),
      .scale_factor (scale_ff),
      .done         (scale_done),
      .scaled       (scaled)
   );

   // The chain takes the new sample once, then rotates a full turn so every
   // entry passes the squarer at the head.
   assign head     = cell_out[WINDOW_DEPTH-1];
   assign shift    = (state_ff == S_SUM) || (state_ff == S_SCALE && scale_done);
   assign chain_in = (state_ff == S_SUM) ? head : scaled;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      sagd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .din   ((i == 0) ? chain_in : cell_out[(i == 0) ? 0 : i - 1]),
         .dout  (cell_out[i])
      );
   end

   assign commit = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      decide.commit = commit;
      decide.active = act_ff;
      decide.cur    = cur_ff;
      decide.now    = now_ff;
   end

   sagd_gesture u_gesture (
      .clock   (clock),
      .reset   (reset),
      .decide  (decide),
      .hold_ms (hold_ff),
      .result  (next_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_SCALE;
         S_SCALE:  if (scale_done) state_in = S_SUM;
         S_SUM:    if (cnt_ff == CNT_W'(WINDOW_DEPTH - 1)) state_in = S_FLUSH;
         S_FLUSH:  state_in = S_MEAN;
         S_MEAN:   state_in = S_VAR;
         S_VAR:    state_in = S_CMP;
         S_CMP:    state_in = S_DECIDE;
         S_DECIDE: if (commit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= (state_ff == S_SUM);
         if (state_ff == S_SUM) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) now_ff <= req_chan.sample_time;
      if (state_ff == S_SCALE && scale_done) begin
         cur_ff   <= scaled;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else if (pipe_vld_ff) begin
         sum_ff   <= sum_ff + SUM_W'(val_ff);
         sqsum_ff <= sqsum_ff + SQSUM_W'(sq_ff);
      end
      val_ff    <= head;
      sq_ff     <= {16'd0, head} * {16'd0, head};
      mean_ff   <= 16'(sum_ff / WINDOW_DEPTH);
      avg_sq_ff <= 32'(sqsum_ff / WINDOW_DEPTH);
      msq_ff    <= {16'd0, mean_ff} * {16'd0, mean_ff};
      if (state_ff == S_CMP) begin
         act_ff <= (thresh_ff < (avg_sq_ff - msq_ff));
      end
      if (commit) rsp_ff <= next_result;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.level        = rsp_ff.level;
   assign rsp_chan.active       = rsp_ff.active;
   assign rsp_chan.gesture_code = rsp_ff.gesture_code;
   assign rsp_chan.window_min   = rsp_ff.window_min;
   assign rsp_chan.window_max   = rsp_ff.window_max;

endmodule

`default_nettype wire

### design/sagd_scaler.sv
// ============================================================================
// Sample scaler
// Clamps a raw sample to the configured range and scales it by the signed
// Q16.16 factor into 0..65535, in two register stages.
// ============================================================================
`default_nettype none

module sagd_scaler import sagd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] raw_sample,
   input  wire logic signed [15:0] raw_low,
   input  wire logic signed [15:0] raw_high,
   input  wire logic signed [32:0] scale_factor,
   output logic                    done,
   output logic [15:0]             scaled
);

   localparam int PROD_W = 50;

   logic signed [15:0]       clamped;
   logic signed [16:0]       diff_in;
   logic signed [16:0]       diff_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     vld1_ff;
   logic                     vld2_ff;

   // An inverted range clamps against the low bound first, then the high one.
   always_comb begin
      clamped = raw_sample;
      if (raw_low < raw_high) begin
         if (clamped < raw_low) clamped = raw_low;
         if (clamped > raw_high) clamped = raw_high;
      end else begin
         if (clamped > raw_low) clamped = raw_low;
         if (clamped < raw_high) clamped = raw_high;
      end
      diff_in = {clamped[15], clamped} - {raw_low[15], raw_low};
      prod_in = PROD_W'(diff_ff) * PROD_W'(scale_factor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= start;
         vld2_ff <= vld1_ff;
      end
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      if (prod_ff[PROD_W-1]) begin
         scaled = 16'd0;
      end else if (|prod_ff[PROD_W-2:32]) begin
         scaled = FULL_VALUE;
      end else begin
         scaled = prod_ff[31:16];
      end
   end

   assign done = vld2_ff;

endmodule

`default_nettype wire

### design/sagd_cell.sv
// ============================================================================
// Window cell
// One entry of the sample window; passes its value on to the next cell.
// ============================================================================
`default_nettype none

module sagd_cell import sagd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        shift,
   input  wire logic [15:0] din,
   output logic [15:0]      dout
);

   logic [15:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= MID_VALUE;
      end else if (shift) begin
         value_ff <= din;
      end
   end

   assign dout = value_ff;

endmodule

`default_nettype wire

### design/sagd_gesture.sv
// ============================================================================
// Gesture tracker
// Keeps the held level, the min/max marks with their times and the gesture
// hold state, and presents the values that a commit would leave behind.
// ============================================================================
`default_nettype none

module sagd_gesture import sagd_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sagd_decide_type decide,
   input  wire logic [15:0]     hold_ms,
   output sagd_result_type      result
);

   logic [15:0] held_ff,   held_in;
   logic [1:0]  gest_ff,   gest_in;
   logic [31:0] until_ff,  until_in;
   logic [15:0] low_ff,    low_in;
   logic [15:0] high_ff,   high_in;
   logic [31:0] low_t_ff,  low_t_in;
   logic [31:0] high_t_ff, high_t_in;

   always_comb begin
      held_in   = held_ff;
      gest_in   = gest_ff;
      until_in  = until_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      low_t_in  = low_t_ff;
      high_t_in = high_t_ff;
      if (!decide.active) begin
         gest_in  = CODE_NONE;
         until_in = 32'd0;
      end else begin
         held_in = decide.cur;
         if (!(decide.now < until_ff)) begin
            // A gesture that outlived its hold rearms the marks at this sample.
            if (gest_ff != CODE_NONE) begin
               gest_in   = CODE_NONE;
               low_in    = decide.cur;
               high_in   = decide.cur;
               low_t_in  = decide.now;
               high_t_in = decide.now;
            end else begin
               if (decide.cur < low_ff) begin
                  low_in   = decide.cur;
                  low_t_in = decide.now;
               end
               if (high_ff < decide.cur) begin
                  high_in   = decide.cur;
                  high_t_in = decide.now;
               end
            end
            if (low_in < EDGE_MARGIN && high_in > (FULL_VALUE - EDGE_MARGIN)) begin
               gest_in  = (low_t_in < high_t_in) ? CODE_UP : CODE_DOWN;
               until_in = decide.now + {16'd0, hold_ms};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= MID_VALUE;
         gest_ff   <= CODE_NONE;
         until_ff  <= 32'd0;
         low_ff    <= 16'd0;
         high_ff   <= FULL_VALUE;
         low_t_ff  <= 32'd0;
         high_t_ff <= 32'd0;
      end else if (decide.commit) begin
         held_ff   <= held_in;
         gest_ff   <= gest_in;
         until_ff  <= until_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         low_t_ff  <= low_t_in;
         high_t_ff <= high_t_in;
      end
   end

   always_comb begin
      result.level        = held_in;
      result.active       = decide.active;
      result.gesture_code = gest_in;
      result.window_min   = low_in;
      result.window_max   = high_in;
   end

endmodule

`default_nettype wire

### verif/sensor_activity_gesture_detector_tb.sv
// ============================================================================
// Sensor activity gesture detector testbench
// Streams timestamped raw samples through the detector under several
// register settings and checks every result against a cycle-free model of
// the clamp, scale, window variance and up/down gesture tracking.
// ============================================================================
`timescale 1ns / 1ps

module sensor_activity_gesture_detector_tb;
   import sagd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [63:0]       csr_pwdata;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   sagd_req_if req_if ();
   sagd_rsp_if rsp_if ();

   sensor_activity_gesture_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Register copies used by the detector model.
   logic signed [15:0] cfg_low;
   logic signed [15:0] cfg_high;
   logic signed [32:0] cfg_scale;
   logic [31:0]        cfg_thresh;
   logic [15:0]        cfg_hold;

   // Detector model state.
   logic [15:0] win_buf [WINDOW_DEPTH];
   int          win_ptr;
   logic [15:0] last_level;
   logic        act;
   logic [1:0]  gest;
   logic [31:0] hold_end;
   logic [15:0] min_val;
   logic [15:0] max_val;
   logic [31:0] min_time;
   logic [31:0] max_time;

   sagd_result_type expected_results [$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  idling_on = 1'b1;

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic reset_model();
      cfg_low    = RST_RAW_LOW;
      cfg_high   = RST_RAW_HIGH;
      cfg_scale  = RST_SCALE;
      cfg_thresh = RST_THRESHOLD;
      cfg_hold   = RST_HOLD_MS;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_buf[i] = MID_VALUE;
      win_ptr    = 0;
      last_level = MID_VALUE;
      act        = 1'b0;
      gest       = CODE_NONE;
      hold_end   = '0;
      min_val    = '0;
      max_val    = FULL_VALUE;
      min_time   = '0;
      max_time   = '0;
   endtask

   function automatic logic [15:0] scale_raw(logic signed [15:0] raw);
      longint lo, hi, r, f, p;
      lo = cfg_low;
      hi = cfg_high;
      r  = raw;
      f  = cfg_scale;
      // An inverted range clamps against the low bound first.
      if (lo < hi) begin
         if (r < lo) r = lo;
         if (r > hi) r = hi;
      end else begin
         if (r > lo) r = lo;
         if (r < hi) r = hi;
      end
      p = (r - lo) * f;
      if (p < 0) return 16'd0;
      p = p >>> 16;
      if (p > 65535) return FULL_VALUE;
      return p[15:0];
   endfunction

   function automatic sagd_result_type track_sample(logic [31:0] now,
                                                    logic signed [15:0] raw);
      logic [15:0]     cur;
      longint unsigned sum, sq, mean, spread;
      sagd_result_type res;
      cur = scale_raw(raw);
      win_ptr = (win_ptr + 1) % WINDOW_DEPTH;
      win_buf[win_ptr] = cur;
      sum = 0;
      sq  = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         sum += longint'(win_buf[i]);
         sq  += longint'(win_buf[i]) * longint'(win_buf[i]);
      end
      mean   = sum / WINDOW_DEPTH;
      spread = sq / WINDOW_DEPTH - mean * mean;
      act    = (longint'(cfg_thresh) < spread);

      if (!act) begin
         gest     = CODE_NONE;
         hold_end = '0;
      end else begin
         last_level = cur;
         if (!(now < hold_end)) begin
            if (gest != CODE_NONE) begin
               // The hold has run out, so both marks restart here.
               gest     = CODE_NONE;
               min_val  = cur;
               max_val  = cur;
               min_time = now;
               max_time = now;
            end else begin
               if (cur < min_val) begin
                  min_val  = cur;
                  min_time = now;
               end
               if (max_val < cur) begin
                  max_val  = cur;
                  max_time = now;
               end
            end
            if (min_val < EDGE_MARGIN && max_val > FULL_VALUE - EDGE_MARGIN) begin
               gest     = (min_time < max_time) ? CODE_UP : CODE_DOWN;
               hold_end = now + {16'd0, cfg_hold};
            end
         end
      end

      res.level        = last_level;
      res.active       = act;
      res.gesture_code = gest;
      res.window_min   = min_val;
      res.window_max   = max_val;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and receiver stalls
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      sagd_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with no sample outstanding");
         end else begin
            want = expected_results.pop_front();
            check_field("level", rsp_if.level, want.level);
            check_field("active", 16'(rsp_if.active), 16'(want.active));
            check_field("gesture_code", 16'(rsp_if.gesture_code), 16'(want.gesture_code));
            check_field("window_min", rsp_if.window_min, want.window_min);
            check_field("window_max", rsp_if.window_max, want.window_max);
         end
      end
   end

   initial begin : drive_result_ready
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sensor_activity_gesture_detector: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers; every task starts and ends on a rising clock edge.
   // ---------------------------------------------------------------------
   task automatic send_sample(logic [31:0] t, logic signed [15:0] raw);
      req_if.valid       <= 1'b1;
      req_if.sample_time <= t;
      req_if.raw_sample  <= raw;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      expected_results.push_back(track_sample(t, raw));
   endtask

   task automatic pause_sender(int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_RAW_LOW:   cfg_low    = value[15:0];
         REG_RAW_HIGH:  cfg_high   = value[15:0];
         REG_SCALE:     cfg_scale  = value[32:0];
         REG_THRESHOLD: cfg_thresh = value[31:0];
         REG_HOLD_MS:   cfg_hold   = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic signed [15:0] lo, logic signed [15:0] hi,
                             logic signed [32:0] scale, logic [31:0] thresh,
                             logic [15:0] hold);
      wait_results_drained();
      write_reg(REG_RAW_LOW,   {48'd0, lo});
      write_reg(REG_RAW_HIGH,  {48'd0, hi});
      write_reg(REG_SCALE,     {31'd0, scale});
      write_reg(REG_THRESHOLD, {32'd0, thresh});
      write_reg(REG_HOLD_MS,   {48'd0, hold});
   endtask

   // Q16.16 factor that maps the raw span onto the full scaled range.
   function automatic logic signed [32:0] fit_scale(logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
      longint span, full;
      full = 64'sd4294901760;
      span = longint'(hi) - longint'(lo);
      if (span == 0) return 33'sd65536;
      return 33'(full / span);
   endfunction

   function automatic logic signed [15:0] near_end(logic signed [15:0] e);
      int v, off;
      off = $urandom_range(0, 10);
      v = int'(e) + off - 5;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   // Mostly swings between the two ends of the range, with calm runs that
   // let the activity drop and some uniform noise in between.
   task automatic run_sample_stream(int n_items);
      logic [31:0]        t;
      logic signed [15:0] raw, calm_raw;
      int                 calm_left, pick, hold_span;
      t = $urandom;
      calm_left = 0;
      calm_raw = '0;
      hold_span = int'(cfg_hold);
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (calm_left > 0) begin
            calm_left--;
            raw = calm_raw;
         end else if (pick < 4) begin
            calm_left = $urandom_range(16, 20);
            calm_raw = 16'($urandom);
            raw = calm_raw;
         end else if (pick < 44) begin
            raw = near_end(cfg_low);
         end else if (pick < 84) begin
            raw = near_end(cfg_high);
         end else begin
            raw = 16'($urandom);
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) t += $urandom_range(1, hold_span / 4 + 1);
         else if (pick < 9) t += $urandom_range(0, 2 * hold_span + 2);
         else t = $urandom;
         if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
         send_sample(t, raw);
      end
   endtask

   task automatic random_stream_phase(bit inverted, bit noise_config, bit wide_bounds,
                                      int n_items);
      logic signed [15:0] a, b, lo, hi;
      logic signed [32:0] scale;
      logic [31:0]        thresh;
      logic [15:0]        hold;
      if (wide_bounds) begin
         lo = 16'sh8000;
         hi = 16'sh7FFF;
      end else begin
         a = 16'($urandom);
         b = 16'($urandom);
         if (a == b) b = a ^ 16'h0001;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
      end
      if (inverted) begin
         a = lo;
         lo = hi;
         hi = a;
      end
      scale  = fit_scale(lo, hi);
      thresh = $urandom_range(0, 1 << 26);
      hold   = 16'($urandom_range(0, 3000));
      if (wide_bounds) begin
         thresh = '0;
         hold = 16'hFFFF;
      end
      if (noise_config) begin
         scale  = {1'($urandom_range(0, 1)), 32'($urandom)};
         thresh = $urandom;
         hold   = 16'($urandom);
      end
      set_config(lo, hi, scale, thresh, hold);
      run_sample_stream(n_items);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_defaults();
      // The first active step sees the reset marks with equal times.
      send_sample(32'd100, 16'sh7FFF);
      send_sample(32'd200, 16'sh8000);
      send_sample(32'hFFFF_FFFF, 16'sd0);
   endtask

   task automatic test_full_swing();
      set_config(-16'sd1000, 16'sd1000, fit_scale(-16'sd1000, 16'sd1000), 32'd1000, 16'd100);
      send_sample(32'd1000, -16'sd1000);
      send_sample(32'd1010, 16'sd1000);
      send_sample(32'd1050, 16'sd5000);
      send_sample(32'd1110, -16'sd5000);
      send_sample(32'd1120, 16'sd1000);
      send_sample(32'd1220, 16'sd1000);
      // The sender holds off here until the detector has answered everything.
      wait_results_drained();
      send_sample(32'd1230, -16'sd1000);
   endtask

   task automatic test_scaling_limits();
      set_config(-16'sd1000, 16'sd1000, -33'sd65536, 32'd0, 16'd0);
      send_sample(32'd10, 16'sd500);
      set_config(-16'sd1000, 16'sd1000, {1'b0, 32'hFFFF_FFFF}, 32'd0, 16'd0);
      send_sample(32'd20, -16'sd999);
      send_sample(32'd30, 16'sh7FFF);
      set_config(-16'sd1000, 16'sd1000, {1'b1, 32'd0}, 32'd0, 16'd0);
      send_sample(32'd40, -16'sd1000);
      send_sample(32'd50, 16'sd1000);
      set_config(-16'sd1000, 16'sd1000, 33'sd98304, 32'd0, 16'd0);
      send_sample(32'd60, -16'sd999);
   endtask

   task automatic test_inverted_range();
      set_config(16'sd1000, -16'sd1000, fit_scale(16'sd1000, -16'sd1000), 32'd500, 16'd50);
      send_sample(32'd100, 16'sh7FFF);
      send_sample(32'd110, 16'sh8000);
      send_sample(32'd120, 16'sd0);
      // Equal bounds take the inverted path and pin every sample.
      set_config(16'sd5, 16'sd5, 33'sd65536, 32'd0, 16'd50);
      send_sample(32'd200, -16'sd7);
   endtask

   task automatic test_time_wrap();
      set_config(-16'sd1000, 16'sd1000, fit_scale(-16'sd1000, 16'sd1000), 32'd0, 16'd100);
      send_sample(32'hFFFF_FFC0, -16'sd1000);
      send_sample(32'hFFFF_FFD0, 16'sd1000);
      send_sample(32'hFFFF_FFE0, 16'sd0);
      send_sample(32'd0, 16'sd1000);
   endtask

   task automatic test_inactive();
      set_config(-16'sd1000, 16'sd1000, fit_scale(-16'sd1000, 16'sd1000),
                 32'hFFFF_FFFF, 16'd500);
      send_sample(32'd500, 16'sd1000);
      send_sample(32'd510, -16'sd1000);
   endtask

   task automatic test_random_swing();
      random_stream_phase(1'b0, 1'b0, 1'b0, 110);
      random_stream_phase(1'b0, 1'b0, 1'b1, 100);
      random_stream_phase(1'b0, 1'b0, 1'b0, 110);
   endtask

   task automatic test_random_inverted();
      random_stream_phase(1'b1, 1'b0, 1'b0, 110);
      random_stream_phase(1'b1, 1'b0, 1'b1, 100);
      random_stream_phase(1'b1, 1'b0, 1'b0, 110);
   endtask

   task automatic test_random_registers();
      random_stream_phase(1'b0, 1'b1, 1'b0, 50);
      random_stream_phase(1'b1, 1'b1, 1'b0, 50);
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      random_stream_phase(1'b0, 1'b0, 1'b0, 110);
   endtask

   initial begin : main
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_if.valid       <= 1'b0;
      req_if.sample_time <= '0;
      req_if.raw_sample  <= '0;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_swing();
      test_scaling_limits();
      test_inverted_range();
      test_time_wrap();
      test_inactive();
      test_random_swing();
      test_random_inverted();
      test_random_registers();
      test_steady_stream();

      wait_results_drained();
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("sensor_activity_gesture_detector: match");
      end else begin
         $display("sensor_activity_gesture_detector: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
design/sagd_pkg.sv
design/sagd_if.sv
design/sagd_scaler.sv
design/sagd_cell.sv
design/sagd_gesture.sv
design/sensor_activity_gesture_detector.sv
verif/sensor_activity_gesture_detector_tb.sv
